[hdl/fdc_pkg.sv]
// Package with payload types, command kinds and helpers for the floppy disk controller.
package fdc_pkg;

  localparam int unsigned IdleIndexCount   = 15;
  localparam int unsigned DataMarkWindow   = 52;
  localparam int unsigned SectorSearchRevs = 5;
  localparam int unsigned VerifyRevs       = 9;

  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [15:0] CrcSeed = 16'hcdb4;
  localparam logic [7:0]  IdMark  = 8'hfe;
  localparam logic [7:0]  DelMark = 8'hf8;
  localparam logic [7:0]  DatMark = 8'hfb;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_SLOT  = 2'd2,
    ACT_RESET = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    REG_CMD  = 2'd0,
    REG_TRK  = 2'd1,
    REG_SEC  = 2'd2,
    REG_DATA = 2'd3
  } reg_addr_e;

  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_IN   = 2'd1,
    STEP_OUT  = 2'd2
  } step_e;

  typedef enum logic [3:0] {
    K_NONE    = 4'd0,
    K_RESTORE = 4'd1,
    K_SEEK    = 4'd2,
    K_STEP    = 4'd3,
    K_STEPIN  = 4'd4,
    K_STEPOUT = 4'd5,
    K_RDSEC   = 4'd6,
    K_WRSEC   = 4'd7,
    K_RDADR   = 4'd8,
    K_RDTRK   = 4'd9,
    K_WRTRK   = 4'd10,
    K_VERIFY  = 4'd11,
    K_STOP    = 4'd12
  } kind_e;

  typedef struct packed {
    logic [1:0] action;
    logic [1:0] reg_addr;
    logic [7:0] write_value;
    logic [7:0] disk_byte;
    logic [1:0] disk_field;
    logic       index_pulse;
    logic       track_zero;
    logic       write_protect;
    logic       disk_present;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       write_enable;
    logic [7:0] write_byte;
    logic [1:0] step_pulse;
    logic       motor_on;
    logic       side_select;
    logic       irq;
    logic       drq;
  } out_item_t;

  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] v);
    logic [15:0] c;
    c = crc ^ {v, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

[hdl/floppy_disk_controller.sv]
// Floppy disk controller: CPU register port, command sequencer and disk byte slot engine.
// Each input item (a register write, a register read, one disk byte slot or a master reset
// change) is taken into an input register and resolved by combinational logic into the
// controller state and a result register; one item is accepted every cycle unless both the
// input register and the skid stage are full. Results are held in an output register
// with a skid stage, so a stalled result consumer does not stop the next transfer from
// being accepted. Commands advance one step for every disk byte slot; ID fields are checked
// with CRC-16/CCITT seeded 0xCDB4, computed one byte per slot.
module floppy_disk_controller #(
  parameter int unsigned IDLE_INDEX_COUNT   = fdc_pkg::IdleIndexCount,
  parameter int unsigned DATA_MARK_WINDOW   = fdc_pkg::DataMarkWindow,
  parameter int unsigned SECTOR_SEARCH_REVS = fdc_pkg::SectorSearchRevs,
  parameter int unsigned VERIFY_REVS        = fdc_pkg::VerifyRevs
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  fdc_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output fdc_pkg::out_item_t out_data_o
);

  localparam logic [10:0] IdleCnt = 11'(IDLE_INDEX_COUNT);
  localparam logic [10:0] MarkCnt = 11'(DATA_MARK_WINDOW);
  localparam logic [10:0] SrchCnt = 11'(SECTOR_SEARCH_REVS);
  localparam logic [10:0] VrfyCnt = 11'(VERIFY_REVS);

  // Input register.
  logic              iv_q;
  fdc_pkg::in_item_t it_q;

  // Output register plus skid stage.
  logic               ov_q, sv_q;
  fdc_pkg::out_item_t od_q, sd_q;

  // Controller state.
  logic [7:0]  cmd_q, trk_q, sec_q, dat_q, sts_q;
  logic        busy_q, irq_q, drq_q, side_q, mot_q, dir_q, tmode_q, rstl_q;
  logic [3:0]  kind_q, stp_q;
  logic [2:0]  sub_q;
  logic [10:0] cnt_q;
  logic [15:0] crca_q, crcr_q;
  logic [7:0]  idb_q [5];

  logic [7:0]  cmd_d, trk_d, sec_d, dat_d, sts_d;
  logic        busy_d, irq_d, drq_d, side_d, mot_d, dir_d, tmode_d, rstl_d;
  logic [3:0]  kind_d, stp_d;
  logic [2:0]  sub_d;
  logic [10:0] cnt_d;
  logic [15:0] crca_d, crcr_d;
  logic [7:0]  idb_d [5];
  fdc_pkg::out_item_t res;

  // A new transfer is taken when the input register is empty or moves on in this cycle.
  assign in_ready_o  = !(iv_q && sv_q);
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

  // The held item is processed only while the skid stage has room for its result.
  logic fire;
  assign fire = iv_q && !sv_q;

  always_comb begin
    logic [7:0] b, val, rd, mark, com;
    logic [1:0] f;
    logic       idx, t0, wp, dp, we, cdone, idmatch;
    logic [7:0] wb;
    logic [1:0] stp;
    logic [1:0] scan;
    logic [10:0] nc;
    logic [3:0] k;

    cmd_d = cmd_q; trk_d = trk_q; sec_d = sec_q; dat_d = dat_q; sts_d = sts_q;
    busy_d = busy_q; irq_d = irq_q; drq_d = drq_q; side_d = side_q; mot_d = mot_q;
    dir_d = dir_q; tmode_d = tmode_q; rstl_d = rstl_q; kind_d = kind_q; stp_d = stp_q;
    sub_d = sub_q; cnt_d = cnt_q; crca_d = crca_q; crcr_d = crcr_q;
    for (int i = 0; i < 5; i++) idb_d[i] = idb_q[i];

    b = it_q.disk_byte; f = it_q.disk_field; val = it_q.write_value;
    idx = it_q.index_pulse; t0 = it_q.track_zero; wp = it_q.write_protect;
    dp = it_q.disk_present;
    rd = 8'hff; we = 1'b0; wb = 8'h00; stp = fdc_pkg::STEP_NONE;
    mark = 8'h00; com = 8'h00; cdone = 1'b0; idmatch = 1'b0; scan = 2'd0;
    nc = 11'd0; k = fdc_pkg::K_NONE;

    case (fdc_pkg::action_e'(it_q.action))
      fdc_pkg::ACT_WRITE, fdc_pkg::ACT_RESET: begin
        com = val;
        if (it_q.action == fdc_pkg::ACT_RESET) begin
          rstl_d = val[0];
          com    = 8'h03;
          if (!val[0]) busy_d = 1'b0;
        end
        if (it_q.action == fdc_pkg::ACT_WRITE) begin
          case (fdc_pkg::reg_addr_e'(it_q.reg_addr))
            fdc_pkg::REG_TRK:  trk_d = val;
            fdc_pkg::REG_SEC:  sec_d = val;
            fdc_pkg::REG_DATA: begin dat_d = val; drq_d = 1'b0; end
            default: ;
          endcase
        end
        if ((it_q.action == fdc_pkg::ACT_WRITE && it_q.reg_addr == fdc_pkg::REG_CMD &&
             rstl_q) || (it_q.action == fdc_pkg::ACT_RESET && !val[0])) begin
          if (com[7:4] == 4'hd) begin
            kind_d = fdc_pkg::K_STOP; stp_d = 4'd0; sub_d = 3'd0;
          end else if (!busy_d) begin
            cmd_d = com;
            if (com[7:4] == 4'h0) k = fdc_pkg::K_RESTORE;
            else if (com[7:4] == 4'h1) k = fdc_pkg::K_SEEK;
            else if (com[7:5] == 3'b001) k = fdc_pkg::K_STEP;
            else if (com[7:5] == 3'b010) k = fdc_pkg::K_STEPIN;
            else if (com[7:5] == 3'b011) k = fdc_pkg::K_STEPOUT;
            else if ((com & 8'he1) == 8'h80) k = fdc_pkg::K_RDSEC;
            else if (com[7:5] == 3'b101) k = fdc_pkg::K_WRSEC;
            else if ((com & 8'hfb) == 8'hc0) k = fdc_pkg::K_RDADR;
            else if ((com & 8'hfb) == 8'he0) k = fdc_pkg::K_RDTRK;
            else if ((com & 8'hfb) == 8'hf0) k = fdc_pkg::K_WRTRK;
            else k = fdc_pkg::K_STOP;
            kind_d = k; stp_d = 4'd0; sub_d = 3'd0;
            busy_d = 1'b1; sts_d = 8'h00; irq_d = 1'b0;
          end
        end
        if (it_q.action == fdc_pkg::ACT_RESET && !val[0]) sec_d = 8'd1;
      end
      fdc_pkg::ACT_READ: begin
        case (fdc_pkg::reg_addr_e'(it_q.reg_addr))
          fdc_pkg::REG_CMD: begin
            sts_d = sts_q & 8'h7e;
            if (!dp) sts_d[7] = 1'b1;
            if (busy_q) sts_d[0] = 1'b1;
            if (!tmode_q) begin
              sts_d = sts_d & 8'h99;
              if (wp) sts_d[6] = 1'b1;
              if (mot_q) sts_d[5] = 1'b1;
              if (t0) sts_d[2] = 1'b1;
              if (dp && idx) sts_d[1] = 1'b1;
            end else begin
              sts_d[1] = drq_q;
            end
            rd = sts_d;
          end
          fdc_pkg::REG_TRK: rd = trk_q;
          fdc_pkg::REG_SEC: rd = sec_q;
          default: begin rd = dat_q; drq_d = 1'b0; end
        endcase
      end
      default: begin
        // Disk byte slot: one sequencer step.
        // Shared ID field scan used by sector search and verify.
        if (sub_q == 3'd0) begin
          if (idx) scan = 2'd1;
          else if (f == 2'd1) begin
            crca_d = fdc_pkg::crc_add(fdc_pkg::CrcSeed, fdc_pkg::IdMark);
            sub_d = 3'd1;
          end
        end else if (sub_q <= 3'd4) begin
          idb_d[sub_q - 3'd1] = b;
          crca_d = fdc_pkg::crc_add(crca_q, b);
          sub_d = sub_q + 3'd1;
        end else if (sub_q == 3'd5) begin
          crcr_d = {b, 8'h00}; sub_d = 3'd6;
        end else begin
          crcr_d = {crcr_q[15:8], b}; sub_d = 3'd0; scan = 2'd2;
        end
        cdone = (cnt_q <= 11'd1);
        nc    = cdone ? 11'd0 : cnt_q - 11'd1;
        idmatch = idb_q[0] == trk_q && idb_q[2] == sec_q &&
                  (!cmd_q[1] || idb_q[1] == {7'd0, cmd_q[3]});

        case (fdc_pkg::kind_e'(kind_q))
          fdc_pkg::K_RESTORE, fdc_pkg::K_SEEK, fdc_pkg::K_STEP,
          fdc_pkg::K_STEPIN, fdc_pkg::K_STEPOUT: begin
            // Scan outputs are discarded for type I commands.
            crca_d = crca_q; crcr_d = crcr_q; sub_d = sub_q;
            for (int i = 0; i < 5; i++) idb_d[i] = idb_q[i];
            if (stp_q == 4'd0) begin
              tmode_d = 1'b0;
              if (cmd_q[3]) mot_d = 1'b1;
              stp_d = 4'd1;
              if (kind_q == fdc_pkg::K_RESTORE) trk_d = 8'hff;
            end else if (kind_q == fdc_pkg::K_RESTORE && stp_q == 4'd1) begin
              if (t0 || trk_q == 8'd0) begin
                if (!t0) sts_d[4] = 1'b1;
                trk_d = 8'd0; stp_d = 4'd2;
              end else begin
                trk_d = trk_q - 8'd1; stp = fdc_pkg::STEP_OUT;
              end
            end else if (kind_q == fdc_pkg::K_SEEK && stp_q == 4'd1) begin
              if (trk_q == dat_q) stp_d = 4'd2;
              else if (trk_q < dat_q) begin trk_d = trk_q + 8'd1; stp = fdc_pkg::STEP_IN; end
              else begin trk_d = trk_q - 8'd1; stp = fdc_pkg::STEP_OUT; end
            end else if (kind_q == fdc_pkg::K_STEP && stp_q == 4'd1) begin
              stp = dir_q ? fdc_pkg::STEP_IN : fdc_pkg::STEP_OUT;
              if (cmd_q[4]) trk_d = dir_q ? trk_q + 8'd1 : trk_q - 8'd1;
              stp_d = 4'd2;
            end else if ((kind_q == fdc_pkg::K_STEPIN || kind_q == fdc_pkg::K_STEPOUT) &&
                         stp_q == 4'd1) begin
              dir_d = (kind_q == fdc_pkg::K_STEPIN); stp_d = 4'd2;
            end else if ((kind_q == fdc_pkg::K_STEPIN || kind_q == fdc_pkg::K_STEPOUT) &&
                         stp_q == 4'd2) begin
              stp = dir_q ? fdc_pkg::STEP_IN : fdc_pkg::STEP_OUT;
              if (cmd_q[4]) trk_d = dir_q ? trk_q + 8'd1 : trk_q - 8'd1;
              stp_d = 4'd3;
            end else begin
              kind_d = fdc_pkg::K_VERIFY; stp_d = 4'd0; sub_d = 3'd0;
            end
          end
          fdc_pkg::K_VERIFY: begin
            if (stp_q != 4'd1) begin
              crca_d = crca_q; crcr_d = crcr_q; sub_d = sub_q;
              for (int i = 0; i < 5; i++) idb_d[i] = idb_q[i];
            end
            if (stp_q == 4'd0) begin
              if (cmd_q[3:2] != 2'b11) begin
                kind_d = fdc_pkg::K_STOP; stp_d = 4'd0; sub_d = 3'd0;
              end else if (!dp) begin
                sts_d[4] = 1'b1; kind_d = fdc_pkg::K_STOP; stp_d = 4'd0; sub_d = 3'd0;
              end else begin
                cnt_d = VrfyCnt; stp_d = 4'd1;
              end
            end else if (stp_q == 4'd1) begin
              if (scan == 2'd1) begin
                side_d = !side_q; cnt_d = nc;
                if (cdone) begin
                  sts_d[4] = 1'b1; kind_d = fdc_pkg::K_STOP; stp_d = 4'd0; sub_d = 3'd0;
                end
              end else if (scan == 2'd2 && idb_q[0] == trk_q) stp_d = 4'd2;
            end else if (stp_q == 4'd2) begin
              if (crca_q != crcr_q) sts_d[3] = 1'b1;
              stp_d = 4'd3;
            end else begin
              kind_d = fdc_pkg::K_STOP; stp_d = 4'd0; sub_d = 3'd0;
            end
          end
          fdc_pkg::K_RDSEC, fdc_pkg::K_WRSEC: begin
            logic wr;
            logic [3:0] s;
            wr = (kind_q == fdc_pkg::K_WRSEC);
            // Write sector has an extra protect check step; align the rest.
            s = (wr && stp_q >= 4'd2) ? stp_q - 4'd1 : stp_q;
            if (!(s == 4'd1 && !(wr && stp_q == 4'd1))) begin
              crca_d = crca_q; crcr_d = crcr_q; sub_d = sub_q;
              for (int i = 0; i < 5; i++) idb_d[i] = idb_q[i];
            end
            if (stp_q == 4'd0) begin
              tmode_d = 1'b1;
              if (!dp) begin kind_d = fdc_pkg::K_STOP; stp_d = 4'd0; sub_d = 3'd0; end
              else begin mot_d = 1'b1; cnt_d = SrchCnt; stp_d = 4'd1; end
            end else if (wr && stp_q == 4'd1) begin
              if (wp) begin
                sts_d[6] = 1'b1; kind_d = fdc_pkg::K_STOP; stp_d = 4'd0; sub_d = 3'd0;
              end else begin drq_d = 1'b1; stp_d = 4'd2; end
            end else if (s == 4'd1) begin
              if (scan == 2'd1) begin
                cnt_d = nc;
                if (cdone) begin
                  sts_d[4] = 1'b1; kind_d = fdc_pkg::K_STOP; stp_d = 4'd0; sub_d = 3'd0;
                end
              end else if (scan == 2'd2 && idmatch) begin
                if (crca_d != crcr_d) begin
                  sts_d[3] = 1'b1; kind_d = fdc_pkg::K_STOP; stp_d = 4'd0; sub_d = 3'd0;
                end else begin cnt_d = MarkCnt; stp_d = stp_q + 4'd1; end
              end
            end else if (s == 4'd2) begin
              if (cnt_q == 11'd0) begin
                sts_d[4] = 1'b1; kind_d = fdc_pkg::K_STOP; stp_d = 4'd0; sub_d = 3'd0;
              end else begin
                cnt_d = cnt_q - 11'd1;
                if (f[1]) begin
                  idb_d[4] = b;
                  if (wr) begin
                    mark = cmd_q[0] ? fdc_pkg::DelMark : fdc_pkg::DatMark;
                    we = 1'b1; wb = mark;
                  end else begin
                    mark = b;
                    if (b == fdc_pkg::DelMark) sts_d[5] = 1'b1;
                    drq_d = 1'b0;
                  end
                  crca_d = fdc_pkg::crc_add(fdc_pkg::CrcSeed, mark);
                  cnt_d = 11'(12'h080 << idb_q[3][1:0]);
                  stp_d = stp_q + 4'd1;
                end
              end
            end else if (s == 4'd3) begin
              if (drq_q) sts_d[2] = 1'b1;
              drq_d = 1'b1;
              cnt_d = nc;
              if (wr) begin
                crca_d = fdc_pkg::crc_add(crca_q, dat_q);
                we = 1'b1; wb = dat_q;
                if (cdone) begin drq_d = 1'b0; stp_d = 4'd5; end
              end else begin
                dat_d = b;
                crca_d = fdc_pkg::crc_add(crca_q, b);
                if (cdone) stp_d = 4'd4;
              end
            end else if (s == 4'd4) begin
              if (wr) begin
                we = 1'b1;
                if (sub_q == 3'd0) begin wb = crca_q[15:8]; sub_d = 3'd1; end
                else begin
                  wb = crca_q[7:0]; sub_d = 3'd0;
                  if (cmd_q[4]) begin sec_d = sec_q + 8'd1; stp_d = 4'd2; cnt_d = SrchCnt; end
                  else stp_d = 4'd6;
                end
              end else begin
                if (sub_q == 3'd0) begin crcr_d = {b, 8'h00}; sub_d = 3'd1; end
                else begin
                  crcr_d = {crcr_q[15:8], b}; sub_d = 3'd0;
                  if (crca_q != {crcr_q[15:8], b}) begin sts_d[3] = 1'b1; stp_d = 4'd5; end
                  else if (cmd_q[4]) begin
                    sec_d = sec_q + 8'd1; stp_d = 4'd1; cnt_d = SrchCnt;
                  end else stp_d = 4'd5;
                end
              end
            end else begin
              kind_d = fdc_pkg::K_STOP; stp_d = 4'd0; sub_d = 3'd0;
            end
          end
          fdc_pkg::K_RDADR, fdc_pkg::K_RDTRK, fdc_pkg::K_WRTRK: begin
            crca_d = crca_q; crcr_d = crcr_q; sub_d = sub_q;
            for (int i = 0; i < 5; i++) idb_d[i] = idb_q[i];
            if (stp_q == 4'd0) begin
              tmode_d = 1'b1;
              if (!dp) begin kind_d = fdc_pkg::K_STOP; stp_d = 4'd0; sub_d = 3'd0; end
              else begin mot_d = 1'b1; cnt_d = SrchCnt; stp_d = 4'd1; end
            end else if (kind_q == fdc_pkg::K_RDADR) begin
              if (stp_q == 4'd1) begin
                if (idx) begin
                  cnt_d = nc;
                  if (cdone) begin
                    sts_d[4] = 1'b1; kind_d = fdc_pkg::K_STOP; stp_d = 4'd0; sub_d = 3'd0;
                  end
                end else if (f == 2'd1) begin
                  crcr_d = 16'h0000;
                  crca_d = fdc_pkg::crc_add(fdc_pkg::CrcSeed, fdc_pkg::IdMark);
                  cnt_d = 11'd6; drq_d = 1'b0; stp_d = 4'd2;
                end
              end else if (stp_q == 4'd2) begin
                if (drq_q) sts_d[2] = 1'b1;
                dat_d = b; drq_d = 1'b1;
                cnt_d = cnt_q - 11'd1;
                if (cnt_d == 11'd0) begin crcr_d = crcr_q | {8'h00, b}; stp_d = 4'd3; end
                else if (cnt_d == 11'd1) crcr_d = {b, 8'h00};
                else begin
                  if (cnt_d == 11'd5) sec_d = b;
                  crca_d = fdc_pkg::crc_add(crca_q, b);
                end
              end else if (stp_q == 4'd3) begin
                if (crca_q != crcr_q) sts_d[3] = 1'b1;
                stp_d = 4'd4;
              end else begin
                kind_d = fdc_pkg::K_STOP; stp_d = 4'd0; sub_d = 3'd0;
              end
            end else if (kind_q == fdc_pkg::K_RDTRK) begin
              if (stp_q == 4'd1) begin
                if (idx) begin drq_d = 1'b0; stp_d = 4'd2; end
              end else if (stp_q == 4'd2) begin
                if (drq_q) sts_d[2] = 1'b1;
                dat_d = b; drq_d = 1'b1;
                if (idx) stp_d = 4'd3;
              end else begin
                kind_d = fdc_pkg::K_STOP; stp_d = 4'd0; sub_d = 3'd0;
              end
            end else begin
              if (stp_q == 4'd1) begin
                if (wp) begin
                  sts_d[6] = 1'b1; kind_d = fdc_pkg::K_STOP; stp_d = 4'd0; sub_d = 3'd0;
                end else begin drq_d = 1'b1; stp_d = 4'd2; end
              end else if (stp_q == 4'd2) begin
                if (idx) stp_d = 4'd3;
              end else if (stp_q == 4'd3) begin
                if (drq_q) sts_d[2] = 1'b1;
                crca_d = fdc_pkg::crc_add(crca_q, dat_q);
                we = 1'b1; wb = dat_q; drq_d = 1'b1;
                if (idx) begin drq_d = 1'b0; stp_d = 4'd4; end
              end else if (stp_q == 4'd4) begin
                stp_d = 4'd5;
              end else begin
                kind_d = fdc_pkg::K_STOP; stp_d = 4'd0; sub_d = 3'd0;
              end
            end
          end
          fdc_pkg::K_STOP: begin
            crca_d = crca_q; crcr_d = crcr_q; sub_d = sub_q;
            for (int i = 0; i < 5; i++) idb_d[i] = idb_q[i];
            if (stp_q == 4'd0) begin
              irq_d = 1'b1; busy_d = 1'b0;
              if (!mot_q || !dp) begin kind_d = fdc_pkg::K_NONE; stp_d = 4'd0; sub_d = 3'd0; end
              else begin cnt_d = IdleCnt; stp_d = 4'd1; end
            end else if (idx) begin
              cnt_d = nc;
              if (cdone) begin
                mot_d = 1'b0; kind_d = fdc_pkg::K_NONE; stp_d = 4'd0; sub_d = 3'd0;
              end
            end
          end
          default: begin
            crca_d = crca_q; crcr_d = crcr_q;
            for (int i = 0; i < 5; i++) idb_d[i] = idb_q[i];
            kind_d = fdc_pkg::K_NONE; stp_d = 4'd0; sub_d = 3'd0;
          end
        endcase
      end
    endcase

    res.read_data    = rd;
    res.write_enable = we;
    res.write_byte   = wb;
    res.step_pulse   = stp;
    res.motor_on     = mot_d;
    res.side_select  = side_d;
    res.irq          = irq_d;
    res.drq          = drq_d;
  end

  // Input register; it holds its item until the item is processed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) iv_q <= 1'b1;
      else if (fire) iv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) it_q <= in_data_i;
  end

  // Output register with skid stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else begin
      if (!ov_q || out_ready_i) begin
        ov_q <= sv_q || fire;
        sv_q <= sv_q && fire;
      end else if (fire) begin
        sv_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!ov_q || out_ready_i) begin
      if (sv_q) begin
        od_q <= sd_q;
        if (fire) sd_q <= res;
      end else if (fire) begin
        od_q <= res;
      end
    end else if (fire) begin
      sd_q <= res;
    end
  end

  // Controller state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q <= '0; trk_q <= '0; sec_q <= '0; dat_q <= '0; sts_q <= '0;
      busy_q <= 1'b1; irq_q <= 1'b1; drq_q <= 1'b0; side_q <= 1'b0; mot_q <= 1'b0;
      dir_q <= 1'b0; tmode_q <= 1'b0; rstl_q <= 1'b0;
      kind_q <= fdc_pkg::K_NONE; stp_q <= '0; sub_q <= '0; cnt_q <= '0;
      crca_q <= '0; crcr_q <= '0;
    end else if (fire) begin
      cmd_q <= cmd_d; trk_q <= trk_d; sec_q <= sec_d; dat_q <= dat_d; sts_q <= sts_d;
      busy_q <= busy_d; irq_q <= irq_d; drq_q <= drq_d; side_q <= side_d; mot_q <= mot_d;
      dir_q <= dir_d; tmode_q <= tmode_d; rstl_q <= rstl_d;
      kind_q <= kind_d; stp_q <= stp_d; sub_q <= sub_d; cnt_q <= cnt_d;
      crca_q <= crca_d; crcr_q <= crcr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      for (int i = 0; i < 5; i++) idb_q[i] <= idb_d[i];
    end
  end

`ifndef ASSERT_OFF
  // The skid stage only fills behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sv_q |-> ov_q) else $error("skid stage full with output register empty");

  // Every taken transfer is held in the input register in the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> iv_q)
    else $error("accepted transfer was not registered");

  // Write data is zero unless the write gate is on.
  a_wb_gated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !od_q.write_enable) |-> (od_q.write_byte == 8'h00))
    else $error("write byte without write enable");

  // A controller that has just returned to idle does not assert busy.
  a_idle_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (kind_q == fdc_pkg::K_NONE && $past(fire) && $past(kind_q) != fdc_pkg::K_NONE)
    |-> !busy_q) else $error("busy with no command");
`endif

endmodule

[tb/sv/floppy_disk_controller_tb.sv]
// Self-checking testbench for the floppy disk controller: directed and randomized traffic.
`timescale 1ns / 100ps

module floppy_disk_controller_tb;
  import fdc_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam logic [7:0] CmdForceInt = 8'hd0;

  typedef struct {
    in_item_t item;
    bit       drain;
  } pend_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  pend_t     pend_q[$];
  out_item_t result_q[$];
  int        n_errors = 0;
  int        n_items = 0;
  int        n_results = 0;
  int        n_scenarios = 0;
  int        cycles = 0;
  bit        send_burst = 1'b0;
  int        send_gap = 0;
  int        rcv_stall = 0;
  int        rcv_hold = 0;
  bit        hold_done = 1'b0;

  // Drive levels of the drive lines for generated disk slots and register reads.
  logic      line_t0 = 1'b0;
  logic      line_wp = 1'b0;
  logic      line_dp = 1'b1;

  floppy_disk_controller u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  // ---------------- controller state prediction ----------------
  logic [7:0]  c_cmd, c_trk, c_sec, c_dat, c_sts;
  logic        c_busy, c_irq, c_drq, c_side, c_motor, c_dir, c_tmode, c_level;
  kind_e       c_kind;
  logic [3:0]  c_step;
  logic [2:0]  c_sub;
  logic [10:0] c_cnt;
  logic [15:0] c_crc, c_crc_rd;
  logic [7:0]  c_idbuf[5];
  logic        o_we;
  logic [7:0]  o_wb;
  step_e       o_step;

  function automatic logic [15:0] crc16_next(logic [15:0] crc, logic [7:0] v);
    logic [15:0] c;
    c = crc ^ {v, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  task automatic ctl_reset();
    c_cmd = '0; c_trk = '0; c_sec = '0; c_dat = '0; c_sts = '0;
    c_busy = 1'b1; c_irq = 1'b1;
    c_drq = 0; c_side = 0; c_motor = 0; c_dir = 0; c_tmode = 0; c_level = 0;
    c_kind = K_NONE; c_step = '0; c_sub = '0; c_cnt = '0; c_crc = '0; c_crc_rd = '0;
    for (int i = 0; i < 5; i++) c_idbuf[i] = '0;
  endtask

  task automatic plan(kind_e k);
    c_kind = k;
    c_step = '0;
    c_sub = '0;
  endtask

  function automatic bit count_down();
    if (c_cnt <= 1) begin
      c_cnt = '0;
      return 1'b1;
    end
    c_cnt = c_cnt - 1'b1;
    return 1'b0;
  endfunction

  task automatic run_command(logic [7:0] com);
    kind_e k;
    if (com[7:4] == 4'hd) begin
      plan(K_STOP);
      return;
    end
    if (c_busy) return;
    c_cmd = com;
    if (com[7:4] == 4'h0) k = K_RESTORE;
    else if (com[7:4] == 4'h1) k = K_SEEK;
    else if ((com & 8'he0) == 8'h20) k = K_STEP;
    else if ((com & 8'he0) == 8'h40) k = K_STEPIN;
    else if ((com & 8'he0) == 8'h60) k = K_STEPOUT;
    else if ((com & 8'he1) == 8'h80) k = K_RDSEC;
    else if ((com & 8'he0) == 8'ha0) k = K_WRSEC;
    else if ((com & 8'hfb) == 8'hc0) k = K_RDADR;
    else if ((com & 8'hfb) == 8'he0) k = K_RDTRK;
    else if ((com & 8'hfb) == 8'hf0) k = K_WRTRK;
    else k = K_STOP;
    plan(k);
    c_busy = 1'b1;
    c_sts = '0;
    c_irq = 1'b0;
  endtask

  task automatic take_byte(logic [7:0] b);
    if (c_drq) c_sts |= 8'h04;
    c_dat = b;
    c_drq = 1'b1;
  endtask

  task automatic emit_byte();
    if (c_drq) c_sts |= 8'h04;
    c_crc = crc16_next(c_crc, c_dat);
    o_we = 1'b1;
    o_wb = c_dat;
    c_drq = 1'b1;
  endtask

  // Returns 0 while searching, 1 on an index pulse, 2 once a whole ID field was read.
  function automatic int scan_id(logic [7:0] b, logic [1:0] f, logic idx);
    if (c_sub == 0) begin
      if (idx) return 1;
      if (f == 2'd1) begin
        c_crc = crc16_next(CrcSeed, IdMark);
        c_sub = 3'd1;
      end
      return 0;
    end
    if (c_sub <= 4) begin
      c_idbuf[c_sub - 1] = b;
      c_crc = crc16_next(c_crc, b);
      c_sub = c_sub + 1'b1;
      return 0;
    end
    if (c_sub == 5) begin
      c_crc_rd = {b, 8'h00};
      c_sub = 3'd6;
      return 0;
    end
    c_crc_rd[7:0] = c_crc_rd[7:0] | b;
    c_sub = '0;
    return 2;
  endfunction

  task automatic data_setup(logic dp);
    c_tmode = 1'b1;
    if (!dp) begin
      plan(K_STOP);
      return;
    end
    c_motor = 1'b1;
    c_cnt = SectorSearchRevs;
    c_step = 4'd1;
  endtask

  task automatic find_sector(logic [7:0] b, logic [1:0] f, logic idx);
    int r;
    r = scan_id(b, f, idx);
    if (r == 1) begin
      if (count_down()) begin
        c_sts |= 8'h10;
        plan(K_STOP);
      end
    end else if (r == 2 && c_idbuf[0] == c_trk && c_idbuf[2] == c_sec &&
                 (!c_cmd[1] || c_idbuf[1] == {7'd0, c_cmd[3]})) begin
      if (c_crc != c_crc_rd) begin
        c_sts |= 8'h08;
        plan(K_STOP);
      end else begin
        c_cnt = DataMarkWindow;
        c_step = c_step + 1'b1;
      end
    end
  endtask

  task automatic find_data_mark(logic [7:0] b, logic [1:0] f, bit writing);
    logic [7:0] mark;
    if (c_cnt == 0) begin
      c_sts |= 8'h10;
      plan(K_STOP);
      return;
    end
    c_cnt = c_cnt - 1'b1;
    if (f < 2) return;
    c_idbuf[4] = b;
    if (writing) begin
      mark = c_cmd[0] ? DelMark : DatMark;
      o_we = 1'b1;
      o_wb = mark;
    end else begin
      mark = b;
      if (b == DelMark) c_sts |= 8'h20;
      c_drq = 1'b0;
    end
    c_crc = crc16_next(CrcSeed, mark);
    c_cnt = 11'h80 << c_idbuf[3][1:0];
    c_step = c_step + 1'b1;
  endtask

  task automatic head_step();
    o_step = c_dir ? STEP_IN : STEP_OUT;
    if (c_cmd[4]) c_trk = c_dir ? c_trk + 1'b1 : c_trk - 1'b1;
  endtask

  task automatic seek_setup();
    c_tmode = 1'b0;
    if (c_cmd[3]) c_motor = 1'b1;
    c_step = 4'd1;
  endtask

  task automatic disk_slot(in_item_t it);
    logic [3:0] s;
    logic [7:0] b;
    logic [1:0] f;
    logic       idx;
    int         r;
    s = c_step;
    b = it.disk_byte;
    f = it.disk_field;
    idx = it.index_pulse;
    case (c_kind)
      K_RESTORE: begin
        if (s == 0) begin
          seek_setup();
          c_trk = 8'hff;
        end else if (s == 1) begin
          if (it.track_zero || c_trk == 0) begin
            if (!it.track_zero) c_sts |= 8'h10;
            c_trk = '0;
            c_step = 4'd2;
          end else begin
            c_trk = c_trk - 1'b1;
            o_step = STEP_OUT;
          end
        end else plan(K_VERIFY);
      end
      K_SEEK: begin
        if (s == 0) seek_setup();
        else if (s == 1) begin
          if (c_trk == c_dat) c_step = 4'd2;
          else if (c_trk < c_dat) begin
            c_trk = c_trk + 1'b1;
            o_step = STEP_IN;
          end else begin
            c_trk = c_trk - 1'b1;
            o_step = STEP_OUT;
          end
        end else plan(K_VERIFY);
      end
      K_STEP: begin
        if (s == 0) seek_setup();
        else if (s == 1) begin
          head_step();
          c_step = 4'd2;
        end else plan(K_VERIFY);
      end
      K_STEPIN, K_STEPOUT: begin
        if (s == 0) seek_setup();
        else if (s == 1) begin
          c_dir = (c_kind == K_STEPIN);
          c_step = 4'd2;
        end else if (s == 2) begin
          head_step();
          c_step = 4'd3;
        end else plan(K_VERIFY);
      end
      K_VERIFY: begin
        if (s == 0) begin
          if (c_cmd[3:2] != 2'b11) plan(K_STOP);
          else if (!it.disk_present) begin
            c_sts |= 8'h10;
            plan(K_STOP);
          end else begin
            c_cnt = VerifyRevs;
            c_step = 4'd1;
          end
        end else if (s == 1) begin
          r = scan_id(b, f, idx);
          if (r == 1) begin
            c_side = ~c_side;
            if (count_down()) begin
              c_sts |= 8'h10;
              plan(K_STOP);
            end
          end else if (r == 2 && c_idbuf[0] == c_trk) c_step = 4'd2;
        end else if (s == 2) begin
          if (c_crc != c_crc_rd) c_sts |= 8'h08;
          c_step = 4'd3;
        end else plan(K_STOP);
      end
      K_RDSEC: begin
        if (s == 0) data_setup(it.disk_present);
        else if (s == 1) find_sector(b, f, idx);
        else if (s == 2) find_data_mark(b, f, 1'b0);
        else if (s == 3) begin
          take_byte(b);
          c_crc = crc16_next(c_crc, c_dat);
          if (count_down()) c_step = 4'd4;
        end else if (s == 4) begin
          if (c_sub == 0) begin
            c_crc_rd = {b, 8'h00};
            c_sub = 3'd1;
          end else begin
            c_crc_rd[7:0] = b;
            c_sub = '0;
            if (c_crc != c_crc_rd) begin
              c_sts |= 8'h08;
              c_step = 4'd5;
            end else if (c_cmd[4]) begin
              c_sec = c_sec + 1'b1;
              c_step = 4'd1;
              c_cnt = SectorSearchRevs;
            end else c_step = 4'd5;
          end
        end else plan(K_STOP);
      end
      K_WRSEC: begin
        if (s == 0) data_setup(it.disk_present);
        else if (s == 1) begin
          if (it.write_protect) begin
            c_sts |= 8'h40;
            plan(K_STOP);
          end else begin
            c_drq = 1'b1;
            c_step = 4'd2;
          end
        end else if (s == 2) find_sector(b, f, idx);
        else if (s == 3) find_data_mark(b, f, 1'b1);
        else if (s == 4) begin
          emit_byte();
          if (count_down()) begin
            c_drq = 1'b0;
            c_step = 4'd5;
          end
        end else if (s == 5) begin
          o_we = 1'b1;
          if (c_sub == 0) begin
            o_wb = c_crc[15:8];
            c_sub = 3'd1;
          end else begin
            o_wb = c_crc[7:0];
            c_sub = '0;
            if (c_cmd[4]) begin
              c_sec = c_sec + 1'b1;
              c_step = 4'd2;
              c_cnt = SectorSearchRevs;
            end else c_step = 4'd6;
          end
        end else plan(K_STOP);
      end
      K_RDADR: begin
        if (s == 0) data_setup(it.disk_present);
        else if (s == 1) begin
          if (idx) begin
            if (count_down()) begin
              c_sts |= 8'h10;
              plan(K_STOP);
            end
          end else if (f == 2'd1) begin
            c_crc_rd = '0;
            c_crc = crc16_next(CrcSeed, IdMark);
            c_cnt = 11'd6;
            c_drq = 1'b0;
            c_step = 4'd2;
          end
        end else if (s == 2) begin
          take_byte(b);
          c_cnt = c_cnt - 1'b1;
          if (c_cnt == 0) begin
            c_crc_rd[7:0] = c_crc_rd[7:0] | c_dat;
            c_step = 4'd3;
          end else if (c_cnt == 1) c_crc_rd = {c_dat, 8'h00};
          else begin
            if (c_cnt == 5) c_sec = c_dat;
            c_crc = crc16_next(c_crc, c_dat);
          end
        end else if (s == 3) begin
          if (c_crc != c_crc_rd) c_sts |= 8'h08;
          c_step = 4'd4;
        end else plan(K_STOP);
      end
      K_RDTRK: begin
        if (s == 0) data_setup(it.disk_present);
        else if (s == 1) begin
          if (idx) begin
            c_drq = 1'b0;
            c_step = 4'd2;
          end
        end else if (s == 2) begin
          take_byte(b);
          if (idx) c_step = 4'd3;
        end else plan(K_STOP);
      end
      K_WRTRK: begin
        if (s == 0) data_setup(it.disk_present);
        else if (s == 1) begin
          if (it.write_protect) begin
            c_sts |= 8'h40;
            plan(K_STOP);
          end else begin
            c_drq = 1'b1;
            c_step = 4'd2;
          end
        end else if (s == 2) begin
          if (idx) c_step = 4'd3;
        end else if (s == 3) begin
          emit_byte();
          if (idx) begin
            c_drq = 1'b0;
            c_step = 4'd4;
          end
        end else if (s == 4) c_step = 4'd5;
        else plan(K_STOP);
      end
      K_STOP: begin
        if (s == 0) begin
          c_irq = 1'b1;
          c_busy = 1'b0;
          if (!c_motor || !it.disk_present) plan(K_NONE);
          else begin
            c_cnt = IdleIndexCount;
            c_step = 4'd1;
          end
        end else if (idx && count_down()) begin
          c_motor = 1'b0;
          plan(K_NONE);
        end
      end
      default: plan(K_NONE);
    endcase
  endtask

  function automatic logic [7:0] live_status(in_item_t it);
    c_sts &= 8'h7e;
    if (!it.disk_present) c_sts |= 8'h80;
    if (c_busy) c_sts |= 8'h01;
    if (!c_tmode) begin
      c_sts &= 8'h99;
      if (it.write_protect) c_sts |= 8'h40;
      if (c_motor) c_sts |= 8'h20;
      if (it.track_zero) c_sts |= 8'h04;
      if (it.disk_present && it.index_pulse) c_sts |= 8'h02;
    end else begin
      c_sts &= 8'hfd;
      if (c_drq) c_sts |= 8'h02;
    end
    return c_sts;
  endfunction

  task automatic controller_predict(in_item_t it, output out_item_t r);
    logic [7:0] rd;
    rd = 8'hff;
    o_we = 1'b0;
    o_wb = '0;
    o_step = STEP_NONE;
    case (action_e'(it.action))
      ACT_WRITE: begin
        case (reg_addr_e'(it.reg_addr))
          REG_CMD: if (c_level) run_command(it.write_value);
          REG_TRK: c_trk = it.write_value;
          REG_SEC: c_sec = it.write_value;
          default: begin
            c_dat = it.write_value;
            c_drq = 1'b0;
          end
        endcase
      end
      ACT_READ: begin
        case (reg_addr_e'(it.reg_addr))
          REG_CMD: rd = live_status(it);
          REG_TRK: rd = c_trk;
          REG_SEC: rd = c_sec;
          default: begin
            rd = c_dat;
            c_drq = 1'b0;
          end
        endcase
      end
      ACT_SLOT: disk_slot(it);
      default: begin
        c_level = it.write_value[0];
        if (!c_level) begin
          c_busy = 1'b0;
          run_command(8'h03);
          c_sec = 8'd1;
        end
      end
    endcase
    r.read_data = rd;
    r.write_enable = o_we;
    r.write_byte = o_wb;
    r.step_pulse = o_step;
    r.motor_on = c_motor;
    r.side_select = c_side;
    r.irq = c_irq;
    r.drq = c_drq;
  endtask

  // ---------------- stimulus building ----------------
  task automatic add(in_item_t it);
    pend_t p;
    p.item = it;
    p.drain = 1'b0;
    pend_q.push_back(p);
    n_items++;
  endtask

  task automatic drain();
    pend_t p;
    p.item = '0;
    p.drain = 1'b1;
    pend_q.push_back(p);
  endtask

  task automatic reg_wr(reg_addr_e a, logic [7:0] v);
    in_item_t it;
    it = in_item_t'($urandom);
    it.action = ACT_WRITE;
    it.reg_addr = a;
    it.write_value = v;
    add(it);
  endtask

  task automatic reg_rd(reg_addr_e a);
    in_item_t it;
    it = in_item_t'($urandom);
    it.action = ACT_READ;
    it.reg_addr = a;
    it.track_zero = line_t0;
    it.write_protect = line_wp;
    it.disk_present = line_dp;
    add(it);
  endtask

  task automatic set_level(logic v);
    in_item_t it;
    it = in_item_t'($urandom);
    it.action = ACT_RESET;
    it.write_value[0] = v;
    add(it);
  endtask

  task automatic slot(logic [7:0] b, logic [1:0] f, logic idx);
    in_item_t it;
    it = in_item_t'($urandom);
    it.action = ACT_SLOT;
    it.disk_byte = b;
    it.disk_field = f;
    it.index_pulse = idx;
    it.track_zero = line_t0;
    it.write_protect = line_wp;
    it.disk_present = line_dp;
    add(it);
  endtask

  task automatic filler(int n);
    for (int i = 0; i < n; i++) slot($urandom, 2'd0, 1'b0);
  endtask

  task automatic id_field(logic [7:0] trk, logic [7:0] sd, logic [7:0] sec,
                          logic [7:0] sz, bit bad);
    logic [15:0] c;
    logic [7:0]  v[4];
    v[0] = trk; v[1] = sd; v[2] = sec; v[3] = sz;
    c = crc16_next(CrcSeed, IdMark);
    slot(IdMark, 2'd1, 1'b0);
    for (int i = 0; i < 4; i++) begin
      slot(v[i], 2'd0, 1'b0);
      c = crc16_next(c, v[i]);
    end
    if (bad) c ^= 16'h0001 << $urandom_range(0, 15);
    slot(c[15:8], 2'd0, 1'b0);
    slot(c[7:0], 2'd0, 1'b0);
  endtask

  // Data field as it passes the head; the CPU reads or writes the data register around it.
  task automatic data_field(int n, bit deleted, bit bad, bit writing);
    logic [15:0] c;
    logic [7:0]  v;
    v = deleted ? DelMark : DatMark;
    c = crc16_next(CrcSeed, v);
    slot(v, deleted ? 2'd3 : 2'd2, 1'b0);
    for (int i = 0; i < n; i++) begin
      v = $urandom;
      if (writing && $urandom_range(0, 19) != 0) reg_wr(REG_DATA, $urandom);
      slot(v, 2'd0, 1'b0);
      c = crc16_next(c, v);
      if (!writing && $urandom_range(0, 19) != 0) reg_rd(REG_DATA);
    end
    if (bad) c ^= 16'h8000 >> $urandom_range(0, 15);
    slot(c[15:8], 2'd0, 1'b0);
    slot(c[7:0], 2'd0, 1'b0);
  endtask

  task automatic stop_command();
    reg_wr(REG_CMD, CmdForceInt | 8'($urandom_range(0, 15)));
    slot($urandom, 2'd0, $urandom_range(0, 1));
    reg_rd(REG_CMD);
  endtask

  task automatic seek_scenario();
    logic [7:0] trk, cmd;
    trk = $urandom_range(0, 80);
    line_t0 = (trk == 0);
    reg_wr(REG_TRK, trk);
    reg_wr(REG_DATA, trk + 8'($urandom_range(0, 8)) - 8'd4);
    cmd = {3'($urandom_range(0, 3)), 5'($urandom)};
    reg_wr(REG_CMD, cmd);
    for (int i = 0; i < 10; i++) begin
      line_t0 = ($urandom_range(0, 4) == 0);
      slot($urandom, 2'd0, 1'b0);
      if ($urandom_range(0, 3) == 0) reg_rd(reg_addr_e'($urandom_range(0, 2)));
    end
    line_t0 = 1'b0;
    if (cmd[3:2] == 2'b11) begin
      filler(2);
      slot($urandom, 2'd0, 1'b1);
      id_field($urandom_range(0, 3) == 0 ? 8'($urandom) : trk, 8'd0, 8'd1, 8'd0,
               $urandom_range(0, 4) == 0);
      filler(3);
    end
    stop_command();
  endtask

  task automatic read_sector_scenario();
    logic [7:0] trk, sec, cmd;
    trk = $urandom_range(0, 79);
    sec = $urandom_range(1, 9);
    cmd = 8'h80 | (8'($urandom) & 8'h1e);
    reg_wr(REG_TRK, trk);
    reg_wr(REG_SEC, sec);
    reg_wr(REG_CMD, cmd);
    filler(3);
    id_field(trk, 8'd0, sec + 8'd1, 8'd0, 1'b0);
    filler(2);
    id_field(trk, ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 1)) : {7'd0, cmd[3]},
             sec, 8'($urandom) & 8'hfc, $urandom_range(0, 9) == 0);
    filler($urandom_range(1, 4));
    data_field(128, $urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0, 1'b0);
    reg_rd(REG_CMD);
    for (int i = 0; i < 6; i++) slot($urandom, 2'd0, 1'b1);
    stop_command();
  endtask

  task automatic write_sector_scenario();
    logic [7:0] trk, sec;
    trk = $urandom_range(0, 79);
    sec = $urandom_range(1, 9);
    reg_wr(REG_TRK, trk);
    reg_wr(REG_SEC, sec);
    reg_wr(REG_CMD, 8'ha0 | (8'($urandom) & 8'h1d));
    slot($urandom, 2'd0, 1'b0);
    line_wp = ($urandom_range(0, 7) == 0);
    slot($urandom, 2'd0, 1'b0);
    line_wp = 1'b0;
    filler(2);
    id_field(trk, 8'd0, sec, 8'($urandom) & 8'hfc, $urandom_range(0, 9) == 0);
    filler(2);
    data_field(128, 1'b0, 1'b0, 1'b1);
    reg_rd(REG_CMD);
    for (int i = 0; i < 6; i++) slot($urandom, 2'd0, 1'b1);
    stop_command();
  endtask

  task automatic address_scenario();
    reg_wr(REG_CMD, 8'hc0 | (8'($urandom) & 8'h04));
    filler(2);
    if ($urandom_range(0, 4) == 0) begin
      for (int i = 0; i < 6; i++) slot($urandom, 2'd0, 1'b1);
    end else begin
      id_field($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 3) == 0);
      for (int i = 0; i < 3; i++) begin
        slot($urandom, 2'd0, 1'b0);
        reg_rd(REG_DATA);
      end
    end
    reg_rd(REG_SEC);
    stop_command();
  endtask

  task automatic track_scenario();
    bit writing;
    writing = $urandom_range(0, 1);
    reg_wr(REG_CMD, (writing ? 8'hf0 : 8'he0) | (8'($urandom) & 8'h04));
    slot($urandom, 2'd0, 1'b0);
    line_wp = writing && ($urandom_range(0, 5) == 0);
    slot($urandom, 2'd0, 1'b0);
    line_wp = 1'b0;
    slot($urandom, 2'd0, 1'b1);
    for (int i = 0; i < 12; i++) begin
      if (writing && $urandom_range(0, 5) != 0) reg_wr(REG_DATA, $urandom);
      slot($urandom, 2'($urandom), 1'b0);
      if (!writing && $urandom_range(0, 5) != 0) reg_rd(REG_DATA);
    end
    slot($urandom, 2'd0, 1'b1);
    filler(3);
    stop_command();
  endtask

  task automatic noise_scenario();
    in_item_t it;
    for (int i = 0; i < 30; i++) begin
      it = in_item_t'($urandom);
      if (it.action == ACT_RESET && $urandom_range(0, 2) != 0) it.action = ACT_SLOT;
      add(it);
    end
    line_dp = 1'b1;
    set_level(1'b1);
    stop_command();
  endtask

  initial begin : stimulus
    int base;
    ctl_reset();
    // Directed part: held in reset, master reset, register extremes and odd commands.
    reg_wr(REG_CMD, 8'h08);
    line_dp = 1'b0;
    reg_rd(REG_CMD);
    line_dp = 1'b1;
    set_level(1'b0);
    line_t0 = 1'b1;
    filler(5);
    line_t0 = 1'b0;
    set_level(1'b1);
    reg_wr(REG_TRK, 8'hff);
    reg_wr(REG_SEC, 8'h00);
    reg_wr(REG_DATA, 8'hff);
    reg_rd(REG_TRK);
    reg_rd(REG_SEC);
    reg_rd(REG_DATA);
    reg_wr(REG_CMD, 8'hc8);
    reg_wr(REG_CMD, 8'h10);
    reg_wr(REG_CMD, CmdForceInt);
    filler(2);
    reg_rd(REG_CMD);
    line_dp = 1'b0;
    slot(8'h00, 2'd3, 1'b1);
    reg_rd(REG_CMD);
    line_dp = 1'b1;
    reg_wr(REG_TRK, 8'h00);
    drain();
    // Random part: well-formed command sequences with random content, plus noise.
    base = n_items;
    while (n_items - base < 650) begin
      send_burst = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1:    seek_scenario();
        2, 3:    read_sector_scenario();
        4, 5:    write_sector_scenario();
        6:       address_scenario();
        7:       track_scenario();
        default: noise_scenario();
      endcase
      n_scenarios++;
      if ($urandom_range(0, 5) == 0) drain();
    end
    send_burst = 1'b0;
    drain();

    while (pend_q.size() != 0 || in_valid) @(posedge clk_i);
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (result_q.size() != 0) n_errors++;
    $display("Ran %0d transfers in %0d random command sequences; %0d results checked.",
             n_items, n_scenarios, n_results);
    $display("Covered seek/step, sector, address and track transfers, resets and noise.");
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Sender: presents pending items, holds them until the transfer, then idles a while.
  always @(posedge clk_i) begin : sender
    logic      nv;
    out_item_t e;
    nv = in_valid;
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        controller_predict(in_data, e);
        result_q.push_back(e);
        nv = 1'b0;
        send_gap = send_burst ? 0 : $urandom_range(0, 6);
      end
      if (!nv) begin
        if (send_gap > 0) send_gap--;
        else if (pend_q.size() != 0) begin
          if (pend_q[0].drain) begin
            if (result_q.size() == 0) void'(pend_q.pop_front());
          end else begin
            in_data <= pend_q.pop_front().item;
            nv = 1'b1;
          end
        end
      end
    end
    in_valid <= nv;
  end

  // Receiver: checks each result against the oldest prediction and stalls at random.
  always @(posedge clk_i) begin : receiver
    logic      nr;
    out_item_t e;
    nr = 1'b0;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        n_results++;
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result %h", $realtime, out_data);
          n_errors++;
        end else begin
          e = result_q.pop_front();
          if (out_data !== e) begin
            $display("%0t: mismatch expected %h actual %h", $realtime, e, out_data);
            if (out_data.read_data !== e.read_data)
              $display("  read_data expected %h actual %h", e.read_data, out_data.read_data);
            if (out_data.write_byte !== e.write_byte ||
                out_data.write_enable !== e.write_enable)
              $display("  write expected %b/%h actual %b/%h", e.write_enable, e.write_byte,
                       out_data.write_enable, out_data.write_byte);
            n_errors++;
          end
        end
        rcv_stall = ((n_results / 64) % 4 == 1) ? 0 : $urandom_range(0, 6);
        if (n_results == 300 && !hold_done) begin
          rcv_hold = 400;
          hold_done = 1'b1;
        end
      end
      if (rcv_hold > 0) rcv_hold--;
      else if (rcv_stall > 0) rcv_stall--;
      else nr = 1'b1;
    end
    out_ready <= nr;
  end

endmodule

[sim.f]
hdl/fdc_pkg.sv
hdl/floppy_disk_controller.sv
tb/sv/floppy_disk_controller_tb.sv
